### sv/lsot_pkg.sv
// Shared types and constants for the layer stacking-order table.
// No dependencies; imported by layer_stack_order_table_core.
package lsot_pkg;

  localparam int DEFAULT_MAX_LAYERS = 256;

  localparam int CMD_W    = 2;
  localparam int LAYER_W  = 8;
  localparam int REQ_W    = 10;
  localparam int HGT_W    = 9;

  // command codes; the fourth code is rejected
  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC = 2'd0,
    CMD_SET   = 2'd1,
    CMD_FREE  = 2'd2
  } cmd_t;

  // height value of a hidden layer, and of an empty stack
  localparam logic signed [HGT_W-1:0] HGT_HIDDEN = '1;

endpackage

### sv/layer_stack_order_table_core.sv
// Layer stacking-order table: slot store, height-to-slot table and top height.
// Depends on lsot_pkg.
//
// Usage:
//   Input channel in_valid/in_ready carries one command item (cmd, layer,
//   requested_height). Output channel out_valid/out_ready returns exactly one
//   result item per command (ok, slot, new_height, top_index, redraw).
//   Two single-port-read memories hold the state: a slot store (used mark and
//   height per slot) and the order table (slot per shown height).
//   Steps from the accepting edge to the edge that raises out_valid:
//     allocate: scan from slot 0 up to the lowest free slot (through the
//       whole store when it is full); the scan reads one slot a cycle.
//     set height / free: straight to the result when nothing moves or the
//       slot is unused, else a shift of n order-table entries (at most
//       MAX_LAYERS-1), one read-and-write-back per cycle, then a final step.
//     invalid command or slot out of range: straight to the result.
//   One item is in work at a time; the next item is accepted as soon as the
//   result sits in the output register, even while the receiver stalls it.
//   A stalled result holds its values until taken.
//   After reset a clearing pass over all MAX_LAYERS slots marks every slot free;
//   in_ready stays low during it. Top height resets to -1.
module layer_stack_order_table_core
  import lsot_pkg::*;
#(
  parameter int MAX_LAYERS = DEFAULT_MAX_LAYERS
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [CMD_W-1:0]         cmd,
  input  logic [LAYER_W-1:0]       layer,
  input  logic signed [REQ_W-1:0]  requested_height,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic                     ok,
  output logic [LAYER_W-1:0]       slot,
  output logic signed [HGT_W-1:0]  new_height,
  output logic signed [HGT_W-1:0]  top_index,
  output logic                     redraw
);

  localparam int HW = $clog2(MAX_LAYERS);
  localparam int CW = (HW + 2 > REQ_W + 1) ? HW + 2 : REQ_W + 1;
  localparam logic signed [CW-1:0] NEG1 = '1;

  typedef struct packed {
    logic              used;
    logic signed [HW:0] height;
  } slot_ent_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_SHIFT,
    ST_FINAL,
    ST_DONE
  } state_t;

  // memories
  slot_ent_t       slot_mem [MAX_LAYERS];
  logic [HW-1:0]   order_mem [MAX_LAYERS];
  slot_ent_t       slot_q;
  logic [HW-1:0]   ord_q;

  logic            slot_we;
  logic [HW-1:0]   slot_waddr;
  slot_ent_t       slot_wdata;
  logic [HW-1:0]   slot_raddr;
  logic            ord_we;
  logic [HW-1:0]   ord_waddr;
  logic [HW-1:0]   ord_wdata;
  logic [HW-1:0]   ord_raddr;

  // control and item registers
  state_t                   state;
  logic [HW-1:0]            clr_ptr;
  logic [HW:0]              scan_ptr;
  logic [HW-1:0]            chk_idx;
  logic                     chk_vld;
  logic [CMD_W-1:0]         cmd_q;
  logic [LAYER_W-1:0]       layer_q;
  logic signed [REQ_W-1:0]  req_q;
  logic signed [HW:0]       top;
  logic signed [HW:0]       hgt_q;
  logic [HW-1:0]            dst;
  logic [HW-1:0]            steps_left;
  logic                     dir_up;
  logic                     final_wr;
  logic                     top_inc;
  logic                     top_dec;
  logic                     wr_pend;
  logic [HW-1:0]            wr_dst;

  logic                     res_ok;
  logic [LAYER_W-1:0]       res_slot;
  logic signed [HGT_W-1:0]  res_nh;
  logic                     res_redraw;

  // height arithmetic for the command under decision
  logic signed [CW-1:0]     req_c, top_c, old_c, lim_c, h1_c, hgt_c;
  logic [HW-1:0]            sh_dst;
  logic [HW-1:0]            sh_steps;
  logic                     sh_up, sh_final, sh_inc, sh_dec;

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    req_c = CW'(req_q);
    top_c = CW'(top);
    old_c = CW'(slot_q.height);
    h1_c  = (req_c < NEG1) ? NEG1 : req_c;
    lim_c = (old_c >= 0) ? top_c : top_c + 2'sd1;
    if (cmd_q == CMD_FREE) begin
      hgt_c = NEG1;
    end else begin
      hgt_c = (h1_c > lim_c) ? lim_c : h1_c;
    end
  end

  // shift plan: dst walks from the vacated place (top+1 for a show) toward the new one (the top for a hide)
  always_comb begin
    sh_dst   = HW'(old_c);
    sh_steps = '0;
    sh_up    = 1'b0;
    sh_final = 1'b1;
    sh_inc   = 1'b0;
    sh_dec   = 1'b0;
    if (old_c > hgt_c) begin
      if (hgt_c >= 0) begin
        sh_steps = HW'(old_c - hgt_c);
      end else begin
        // hide: close the gap above, drop the top
        sh_up    = 1'b1;
        sh_steps = HW'(top_c - old_c);
        sh_final = 1'b0;
        sh_dec   = 1'b1;
      end
    end else begin
      if (old_c >= 0) begin
        sh_up    = 1'b1;
        sh_steps = HW'(hgt_c - old_c);
      end else begin
        // show: open a gap from the top down
        sh_dst   = HW'(top_c + 2'sd1);
        sh_steps = HW'(top_c + 2'sd1 - hgt_c);
        sh_inc   = 1'b1;
      end
    end
  end

  // memory port selection
  always_comb begin
    case (state)
      ST_IDLE: slot_raddr = HW'(layer);
      ST_SCAN: slot_raddr = scan_ptr[HW-1:0];
      default: slot_raddr = '0;
    endcase
    ord_raddr = dir_up ? dst + 1'b1 : dst - 1'b1;

    slot_we    = 1'b0;
    slot_waddr = '0;
    slot_wdata = '0;
    case (state)
      ST_CLEAR: begin
        slot_we    = 1'b1;
        slot_waddr = clr_ptr;
      end
      ST_SCAN: begin
        if (chk_vld && !slot_q.used) begin
          slot_we    = 1'b1;
          slot_waddr = chk_idx;
          slot_wdata = '{used: 1'b1, height: '1};
        end
      end
      ST_DECIDE: begin
        if (slot_q.used) begin
          slot_we    = 1'b1;
          slot_waddr = HW'(layer_q);
          slot_wdata = '{used: (cmd_q != CMD_FREE), height: (HW+1)'(hgt_c)};
        end
      end
      ST_SHIFT: begin
        if (wr_pend) begin
          slot_we    = 1'b1;
          slot_waddr = ord_q;
          slot_wdata = '{used: 1'b1, height: $signed({1'b0, wr_dst})};
        end
      end
      default: slot_we = 1'b0;
    endcase

    ord_we    = 1'b0;
    ord_waddr = wr_dst;
    ord_wdata = ord_q;
    if (wr_pend) begin
      ord_we = 1'b1;
    end else if (state == ST_FINAL && final_wr) begin
      ord_we    = 1'b1;
      ord_waddr = hgt_q[HW-1:0];
      ord_wdata = HW'(layer_q);
    end
  end

  always_ff @(posedge clk) begin
    if (slot_we) begin
      slot_mem[slot_waddr] <= slot_wdata;
    end
    slot_q <= slot_mem[slot_raddr];
  end

  always_ff @(posedge clk) begin
    if (ord_we) begin
      order_mem[ord_waddr] <= ord_wdata;
    end
    ord_q <= order_mem[ord_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_ptr   <= '0;
      top       <= '1;
      chk_vld   <= 1'b0;
      wr_pend   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != ST_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          clr_ptr <= clr_ptr + 1'b1;
          if (clr_ptr == HW'(MAX_LAYERS - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_valid) begin
            cmd_q   <= cmd;
            layer_q <= layer;
            req_q   <= requested_height;
            if (cmd == CMD_ALLOC) begin
              scan_ptr <= '0;
              chk_vld  <= 1'b0;
              state    <= ST_SCAN;
            end else if ((cmd == CMD_SET || cmd == CMD_FREE) &&
                         32'(layer) < MAX_LAYERS) begin
              state <= ST_DECIDE;
            end else begin
              res_ok     <= 1'b0;
              res_slot   <= layer;
              res_nh     <= HGT_HIDDEN;
              res_redraw <= 1'b0;
              state      <= ST_DONE;
            end
          end
        end
        ST_SCAN: begin
          res_nh     <= HGT_HIDDEN;
          res_redraw <= 1'b0;
          if (chk_vld && !slot_q.used) begin
            res_ok   <= 1'b1;
            res_slot <= LAYER_W'(chk_idx);
            state    <= ST_DONE;
          end else if (scan_ptr == (HW+1)'(MAX_LAYERS)) begin
            chk_vld <= 1'b0;
            if (!chk_vld) begin
              res_ok   <= 1'b0;
              res_slot <= '0;
              state    <= ST_DONE;
            end
          end else begin
            chk_vld  <= 1'b1;
            chk_idx  <= scan_ptr[HW-1:0];
            scan_ptr <= scan_ptr + 1'b1;
          end
        end
        ST_DECIDE: begin
          res_slot <= layer_q;
          if (!slot_q.used) begin
            res_ok     <= 1'b0;
            res_nh     <= HGT_HIDDEN;
            res_redraw <= 1'b0;
            state      <= ST_DONE;
          end else begin
            res_ok <= 1'b1;
            res_nh <= hgt_c[HGT_W-1:0];
            if (hgt_c == old_c) begin
              res_redraw <= 1'b0;
              state      <= ST_DONE;
            end else begin
              res_redraw <= 1'b1;
              hgt_q      <= (HW+1)'(hgt_c);
              dst        <= sh_dst;
              steps_left <= sh_steps;
              dir_up     <= sh_up;
              final_wr   <= sh_final;
              top_inc    <= sh_inc;
              top_dec    <= sh_dec;
              state      <= ST_SHIFT;
            end
          end
        end
        ST_SHIFT: begin
          // read a neighbor now, write it back one place over next cycle
          wr_pend <= (steps_left != '0);
          if (steps_left != '0) begin
            wr_dst     <= dst;
            dst        <= dir_up ? dst + 1'b1 : dst - 1'b1;
            steps_left <= steps_left - 1'b1;
          end else begin
            state <= ST_FINAL;
          end
        end
        ST_FINAL: begin
          if (top_inc) begin
            top <= top + 2'sd1;
          end else if (top_dec) begin
            top <= top - 2'sd1;
          end
          state <= ST_DONE;
        end
        ST_DONE: begin
          if (!out_valid || out_ready) begin
            ok         <= res_ok;
            slot       <= res_slot;
            new_height <= res_nh;
            top_index  <= top_c[HGT_W-1:0];
            redraw     <= res_redraw;
            out_valid  <= 1'b1;
            state      <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // the top height stays within the table
  assert property (@(posedge clk) disable iff (rst)
    (top_c >= NEG1) && (top_c < $signed(CW'(MAX_LAYERS))))
    else $error("top height out of range");

  // write-backs of shifted entries happen only inside the shift walk
  assert property (@(posedge clk) disable iff (rst)
    wr_pend |-> (state == ST_SHIFT))
    else $error("order write-back outside shift");

  // every issued neighbor read is written back in the next cycle
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_SHIFT && steps_left != '0) |=> wr_pend)
    else $error("lost order write-back");

  // a result appears only from the completion state
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_DONE))
    else $error("result raised outside completion");

endmodule
